### hdl/gpsr_pkg.sv
// ----------------------------------------------------------------------------
// gpsr_pkg
// Shared types and constants of the game-pad serial responder.
// ----------------------------------------------------------------------------
package gpsr_pkg;

	localparam int unsigned InDataW  = 24;
	localparam int unsigned OutDataW = 8;
	localparam int unsigned AddrW    = 3;
	localparam int unsigned DataW    = 32;

	localparam logic [7:0] RespIdle  = 8'hFF;
	localparam logic [7:0] CardMask  = 8'hF0;
	localparam logic [7:0] IdByte    = 8'h41;
	localparam logic [7:0] ReadyByte = 8'h5A;
	localparam logic [7:0] QueryRst  = 8'h42;

	localparam logic       OpSelect = 1'b0;
	localparam logic       OpShift  = 1'b1;
	localparam logic [0:0] RegQuery = 1'b0;

	localparam logic [2:0] ByteFirst  = 3'd0;
	localparam logic [2:0] ByteQuery  = 3'd1;
	localparam logic [2:0] ByteBtnLo  = 3'd2;
	localparam logic [2:0] ByteBtnHi  = 3'd3;
	localparam logic [2:0] LastBit    = 3'd7;

	typedef struct packed {
		logic       op;
		logic       select_level;
		logic       command_bit;
		logic [7:0] buttons_first;
		logic [7:0] buttons_second;
	} item_t;

	typedef struct packed {
		logic response_bit;
		logic ack_request;
		logic card_mode;
	} result_t;

endpackage

### hdl/game_pad_serial_responder.sv
// ----------------------------------------------------------------------------
// game_pad_serial_responder
// Device side of a digital game-pad serial link, one event per item.
// ----------------------------------------------------------------------------
// Each input item on s_axis is one link event: tuser carries the kind
// (select line sample or shift clock edge), tdata the select level, the
// command bit and both active-low button bytes. Each item yields exactly
// one result item on m_axis: the response bit level, an acknowledge
// request and the memory-card flag.
// Each item passes the input register, then the step logic into the
// result register. One item is accepted every cycle while the output
// stream takes results; the interface state carries from item to item,
// updated as each item moves into the result register.
// Reset clears the interface state (response idle high, select seen
// high) and loads the query register with 0x42. When m_axis_tready is
// low, the result register holds and the input register fills, then
// s_axis_tready drops; nothing is lost. The user writes the query register
// over APB at address 0 only while the stream is idle; the block does not check.
// ----------------------------------------------------------------------------
module game_pad_serial_responder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [0] select_level, [1] command_bit, [9:2] buttons_first, [17:10] buttons_second
	input  logic [gpsr_pkg::InDataW-1:0]   s_axis_tdata,
	// [0] op
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [0] response_bit, [1] ack_request, [2] card_mode
	output logic [gpsr_pkg::OutDataW-1:0]  m_axis_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gpsr_pkg::AddrW-1:0]     paddr,
	input  logic [gpsr_pkg::DataW-1:0]     pwdata,
	output logic [gpsr_pkg::DataW-1:0]     prdata,
	output logic                           pready
);

	logic [7:0]        query_q;
	gpsr_pkg::item_t   in_item;
	gpsr_pkg::result_t res;
	gpsr_pkg::result_t out_res;
	logic              res_valid;
	logic              res_ready;
	logic [0:0]        reg_index;

	assign pready    = 1'b1;
	assign reg_index = paddr[gpsr_pkg::AddrW-1 -: 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= gpsr_pkg::QueryRst;
		end else if (psel && penable && pwrite && pready && reg_index == gpsr_pkg::RegQuery) begin
			query_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_index == gpsr_pkg::RegQuery) begin
			prdata = {{(gpsr_pkg::DataW-8){1'b0}}, query_q};
		end
	end

	always_comb begin
		in_item.op             = s_axis_tuser;
		in_item.select_level   = s_axis_tdata[0];
		in_item.command_bit    = s_axis_tdata[1];
		in_item.buttons_first  = s_axis_tdata[9:2];
		in_item.buttons_second = s_axis_tdata[17:10];
	end

	gpsr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.in_item       (in_item),
		.query_command (query_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	gpsr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {5'd0, out_res.card_mode, out_res.ack_request, out_res.response_bit};

endmodule

### hdl/gpsr_core.sv
// ----------------------------------------------------------------------------
// gpsr_core
// Input register, interface state and the per-item step logic.
// ----------------------------------------------------------------------------
module gpsr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gpsr_pkg::item_t   in_item,
	input  logic [7:0]        query_command,
	output logic              res_valid,
	input  logic              res_ready,
	output gpsr_pkg::result_t res
);

	logic            valid_s1;
	gpsr_pkg::item_t item_s1;
	logic            advance;

	logic [2:0] bit_index_q;
	logic [2:0] byte_index_q;
	logic [7:0] in_shift_q;
	logic [7:0] out_byte_q;
	logic       card_flag_q;
	logic       select_prev_q;
	logic       response_level_q;

	logic [2:0] bit_index_d;
	logic [2:0] byte_index_d;
	logic [7:0] in_shift_d;
	logic [7:0] out_byte_d;
	logic       card_flag_d;
	logic       select_prev_d;
	logic       response_level_d;
	logic       ack_d;
	logic [7:0] shift_base;
	logic [7:0] out_base;

	assign advance   = valid_s1 & res_ready;
	assign in_ready  = ~valid_s1 | res_ready;
	assign res_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		bit_index_d      = bit_index_q;
		byte_index_d     = byte_index_q;
		in_shift_d       = in_shift_q;
		out_byte_d       = out_byte_q;
		card_flag_d      = card_flag_q;
		select_prev_d    = select_prev_q;
		response_level_d = response_level_q;
		ack_d            = 1'b0;
		shift_base       = (bit_index_q == 3'd0) ? 8'h00 : in_shift_q;
		out_base         = (bit_index_q == 3'd0 && byte_index_q == gpsr_pkg::ByteFirst) ?
			gpsr_pkg::RespIdle : out_byte_q;
		if (item_s1.op == gpsr_pkg::OpSelect) begin
			if (item_s1.select_level && !select_prev_q) begin
				bit_index_d      = 3'd0;
				byte_index_d     = gpsr_pkg::ByteFirst;
				in_shift_d       = 8'h00;
				card_flag_d      = 1'b0;
				response_level_d = 1'b1;
			end
			select_prev_d = item_s1.select_level;
		end else if (!card_flag_q) begin
			out_byte_d       = out_base;
			response_level_d = out_base[bit_index_q];
			in_shift_d       = shift_base | (8'({7'd0, item_s1.command_bit}) << bit_index_q);
			bit_index_d      = bit_index_q + 3'd1;
			if (bit_index_q == gpsr_pkg::LastBit) begin
				if (byte_index_q == gpsr_pkg::ByteFirst &&
						(in_shift_d & gpsr_pkg::CardMask) != 8'h00) begin
					card_flag_d = 1'b1;
				end else begin
					byte_index_d = byte_index_q + 3'd1;
					case (byte_index_q)
						gpsr_pkg::ByteFirst: begin
							out_byte_d = gpsr_pkg::IdByte;
							ack_d      = 1'b1;
						end
						gpsr_pkg::ByteQuery: begin
							if (in_shift_d == query_command) begin
								out_byte_d = gpsr_pkg::ReadyByte;
								ack_d      = 1'b1;
							end else begin
								byte_index_d = gpsr_pkg::ByteFirst;
							end
						end
						gpsr_pkg::ByteBtnLo: begin
							out_byte_d = item_s1.buttons_first;
							ack_d      = 1'b1;
						end
						gpsr_pkg::ByteBtnHi: begin
							out_byte_d = item_s1.buttons_second;
							ack_d      = 1'b1;
						end
						default: begin
							byte_index_d = gpsr_pkg::ByteFirst;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_index_q      <= 3'd0;
			byte_index_q     <= gpsr_pkg::ByteFirst;
			in_shift_q       <= 8'h00;
			out_byte_q       <= gpsr_pkg::RespIdle;
			card_flag_q      <= 1'b0;
			select_prev_q    <= 1'b1;
			response_level_q <= 1'b1;
		end else if (advance) begin
			bit_index_q      <= bit_index_d;
			byte_index_q     <= byte_index_d;
			in_shift_q       <= in_shift_d;
			out_byte_q       <= out_byte_d;
			card_flag_q      <= card_flag_d;
			select_prev_q    <= select_prev_d;
			response_level_q <= response_level_d;
		end
	end

	always_comb begin
		res.response_bit = response_level_d;
		res.ack_request  = ack_d;
		res.card_mode    = card_flag_d;
	end

endmodule

### hdl/gpsr_out.sv
// ----------------------------------------------------------------------------
// gpsr_out
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module gpsr_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  gpsr_pkg::result_t res,
	output logic              out_valid,
	input  logic              out_ready,
	output gpsr_pkg::result_t out_res
);

	logic valid_q;

	assign res_ready = ~valid_q | out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res <= res;
		end
	end

endmodule
